>>> hdl/rmq_pkg.sv
// Shared widths, codes and controller states for the range mode query block.
package rmq_pkg;

    localparam int IDENT_W  = 10;
    localparam int RANGE_W  = 11;
    localparam int COUNT_W  = 11;
    localparam int ID_COUNT = 1 << IDENT_W;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_COUNT,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

>>> hdl/rmq_ifs.sv
// Valid/ready channel interfaces for the command input and the result output.
interface rmq_in_if;
    import rmq_pkg::*;

    logic               valid;
    logic               ready;
    logic               cmd;
    logic [IDENT_W-1:0] ident;
    logic [RANGE_W-1:0] range_first;
    logic [RANGE_W-1:0] range_last;

    modport source (output valid, output cmd, output ident, output range_first,
                    output range_last, input ready);
    modport sink   (input valid, input cmd, input ident, input range_first,
                    input range_last, output ready);
endinterface

interface rmq_out_if;
    import rmq_pkg::*;

    logic               valid;
    logic               ready;
    logic [IDENT_W-1:0] mode_ident;
    logic [COUNT_W-1:0] mode_count;

    modport source (output valid, output mode_ident, output mode_count, input ready);
    modport sink   (input valid, input mode_ident, input mode_count, output ready);
endinterface

>>> hdl/range_mode_query.sv
// Range mode query: identifier store, per-query count memory and mode search.
//
// A load transaction (cmd 0) appends one identifier to the sequence memory;
// loads beyond MAX_LENGTH are dropped. A query transaction
// (cmd 1) returns the most frequent identifier of the one-based inclusive
// range [range_first, range_last], larger identifier winning ties, with its
// count. range_first of 0 counts as 1, range_last is clamped to the number of
// identifiers loaded, and an empty range returns the largest identifier loaded
// with count 0. The sequence memory and the count memory each give one access
// per cycle, and a query walks its range twice, once to zero the counters it
// touches and once to count. The input is not ready while a query runs;
// loads are taken back to back. A finished result sits in an output register,
// so the next transaction is accepted while it waits. There is no clearing
// pass after reset: counters are zeroed by each query for exactly the
// identifiers it reads.
module range_mode_query #(
    parameter int MAX_LENGTH = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmq_in_if.sink     i_in,
    rmq_out_if.source  o_out
);
    import rmq_pkg::*;

    localparam int PW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;  // position
    localparam int LW = $clog2(MAX_LENGTH + 1);                     // length / count
    localparam int CW = (LW > RANGE_W) ? LW : RANGE_W;              // range compare
    localparam int OW = (LW > COUNT_W) ? LW : COUNT_W;              // count output

    // Memories: sequence store and per-identifier counters.
    logic [IDENT_W-1:0] seq_mem [MAX_LENGTH];
    logic [LW-1:0]      cnt_mem [ID_COUNT];

    // Controller
    t_state r_state, n_state;

    logic [LW-1:0]      r_len;
    logic [IDENT_W-1:0] r_largest;
    logic [PW-1:0]      r_pos, r_start, r_end;

    // Stage B: sequence read data valid; stage C: count read data valid.
    logic               r_b_v, r_b_cnt, r_b_last;
    logic               r_c_v, r_c_cnt, r_c_last;
    logic [IDENT_W-1:0] r_seq_q, r_c_id;
    logic [LW-1:0]      r_cnt_q;

    // Last write to the count memory, forwarded to a same-id read one behind.
    logic               r_fw_v;
    logic [IDENT_W-1:0] r_fw_id;
    logic [LW-1:0]      r_fw_cnt;

    logic [IDENT_W-1:0] r_best_id;
    logic [LW-1:0]      r_best_cnt;

    logic               r_out_valid;
    logic [IDENT_W-1:0] r_out_ident;
    logic [COUNT_W-1:0] r_out_count;

    // Control decode
    logic in_ready, issue_v, issue_cnt, issue_last, at_end, out_free;
    logic acc_load, acc_query;

    // Query range setup
    logic [CW-1:0] first_x, last_x, rlast_x, len_x;
    logic          q_empty;

    // Stage C arithmetic
    logic [LW-1:0] c_old, c_new;
    logic          c_better;
    logic [OW-1:0] best_ext;

    assign at_end    = (r_pos == r_end);
    assign out_free  = !r_out_valid || o_out.ready;
    assign acc_load  = i_in.valid && in_ready && (i_in.cmd == CMD_LOAD);
    assign acc_query = i_in.valid && in_ready && (i_in.cmd == CMD_QUERY);

    always_comb begin
        first_x = CW'(i_in.range_first);
        if (first_x == '0) begin
            first_x = CW'(1);
        end
        len_x   = CW'(r_len);
        rlast_x = CW'(i_in.range_last);
        last_x  = (rlast_x > len_x) ? len_x : rlast_x;
        q_empty = (first_x > last_x);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc_query) begin
                    n_state = q_empty ? ST_DONE : ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                if (at_end) begin
                    n_state = ST_COUNT;
                end
            end
            ST_COUNT: begin
                if (at_end) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_c_v && r_c_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Controller outputs
    always_comb begin
        in_ready   = 1'b0;
        issue_v    = 1'b0;
        issue_cnt  = 1'b0;
        issue_last = 1'b0;
        unique case (r_state)
            ST_IDLE:  in_ready = 1'b1;
            ST_CLEAR: issue_v  = 1'b1;
            ST_COUNT: begin
                issue_v    = 1'b1;
                issue_cnt  = 1'b1;
                issue_last = at_end;
            end
            ST_DRAIN: ;
            ST_DONE:  ;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Load path: length and largest identifier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_largest <= '0;
        end else if (acc_load && (r_len < LW'(MAX_LENGTH))) begin
            r_len <= LW'(r_len + 1'b1);
            if (i_in.ident > r_largest) begin
                r_largest <= i_in.ident;
            end
        end
    end

    // Sequence memory: write on load, read every cycle at the walk position
    always_ff @(posedge i_clk) begin
        if (acc_load && (r_len < LW'(MAX_LENGTH))) begin
            seq_mem[r_len[PW-1:0]] <= i_in.ident;
        end
        r_seq_q <= seq_mem[r_pos];
    end

    // Walk position over the range, twice
    always_ff @(posedge i_clk) begin
        if (acc_query) begin
            r_start <= PW'(first_x - CW'(1));
            r_end   <= PW'(last_x - CW'(1));
            r_pos   <= PW'(first_x - CW'(1));
        end else if (issue_v) begin
            r_pos <= at_end ? r_start : PW'(r_pos + 1'b1);
        end
    end

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v  <= 1'b0;
            r_c_v  <= 1'b0;
            r_fw_v <= 1'b0;
        end else begin
            r_b_v  <= issue_v;
            r_c_v  <= r_b_v;
            r_fw_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_cnt  <= issue_cnt;
        r_b_last <= issue_last;
        r_c_cnt  <= r_b_cnt;
        r_c_last <= r_b_last;
        r_c_id   <= r_seq_q;
    end

    // Count memory read-modify-write; a read made in the same cycle as a write to
    // the same identifier misses it, so that case takes the forwarded value.
    assign c_old = (r_fw_v && (r_fw_id == r_c_id)) ? r_fw_cnt : r_cnt_q;
    assign c_new = r_c_cnt ? LW'(c_old + 1'b1) : '0;
    assign c_better = (c_new > r_best_cnt) ||
                      ((c_new == r_best_cnt) && (r_c_id > r_best_id));

    always_ff @(posedge i_clk) begin
        r_cnt_q <= cnt_mem[r_seq_q];
        if (r_c_v) begin
            cnt_mem[r_c_id] <= c_new;
        end
        r_fw_id  <= r_c_id;
        r_fw_cnt <= c_new;
    end

    // Running mode
    always_ff @(posedge i_clk) begin
        if (acc_query) begin
            r_best_id  <= r_largest;
            r_best_cnt <= '0;
        end else if (r_c_v && r_c_cnt && c_better) begin
            r_best_id  <= r_c_id;
            r_best_cnt <= c_new;
        end
    end

    // Output register
    assign best_ext = OW'(r_best_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && out_free) begin
            r_out_ident <= r_best_id;
            r_out_count <= best_ext[COUNT_W-1:0];
        end
    end

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.mode_ident = r_out_ident;
    assign o_out.mode_count = r_out_count;

endmodule

>>> hdl/rmq_checker.sv
// Port-level checks for the range mode query block, bound to its top level.
module rmq_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_in_cmd,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [rmq_pkg::IDENT_W-1:0] i_out_ident,
    input logic [rmq_pkg::COUNT_W-1:0] i_out_count
);
    import rmq_pkg::*;

    // The input is ready again right after a load.
    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_cmd == CMD_LOAD)) |=> i_in_ready)
        else $error("input not ready after load transaction");

    // The input is not ready right after a query is accepted.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_cmd == CMD_QUERY)) |=> !i_in_ready)
        else $error("input ready right after query transaction");

    // A new result only appears at the end of a query, never while idle.
    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result raised while block was idle");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_ident) && $stable(i_out_count)))
        else $error("result dropped or changed while stalled");

endmodule

bind range_mode_query rmq_checker u_rmq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_cmd    (i_in.cmd),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_ident (o_out.mode_ident),
    .i_out_count (o_out.mode_count)
);

>>> tb/tb_range_mode_query.sv
// Self-checking testbench for the range mode query block.
`timescale 1ns / 100ps

module tb_range_mode_query;
    import rmq_pkg::*;

    localparam int MAX_LEN     = 1024;
    localparam int RAND_ITEMS  = 560;
    // A full-store query walks 1024 positions twice; allow plenty of margin.
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 2 * MAX_LEN + 16;

    // Idle profiles: slow sink, slow source, then free-running.
    typedef enum int {
        PACE_SLOW_SINK,
        PACE_SLOW_SOURCE,
        PACE_FREE
    } t_pace;

    typedef struct {
        logic               cmd;
        logic [IDENT_W-1:0] ident;
        logic [RANGE_W-1:0] range_first;
        logic [RANGE_W-1:0] range_last;
        t_pace              pace;
    } t_cmd_item;

    typedef struct packed {
        logic [IDENT_W-1:0] ident;
        logic [COUNT_W-1:0] count;
    } t_mode_result;

    logic i_clk;
    logic i_rst_n;

    rmq_in_if  cmd_if ();
    rmq_out_if mode_if ();

    range_mode_query #(
        .MAX_LENGTH(MAX_LEN)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (mode_if)
    );

    // Stimulus side
    t_cmd_item    cmd_queue[$];
    t_cmd_item    cmd_on_bus;
    t_pace        gen_pace;
    int           gen_len;
    logic [IDENT_W-1:0] pool_base;

    // Predictor state: our own copy of the sequence store
    logic [IDENT_W-1:0] seq_mem [MAX_LEN];
    int                 seq_len;
    logic [IDENT_W-1:0] peak_ident;
    t_mode_result       mode_expect[$];

    // Pace of the transaction last put on the input; steers the sink's idling
    t_pace bus_pace;
    int    err_cnt;
    int    stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor. A load appends (dropped once the store is full) and
    // tracks the largest identifier. A query clamps its range, counts from
    // scratch and keeps the most frequent identifier, larger one on a tie.
    // An empty range leaves the largest identifier with count zero.
    // ------------------------------------------------------------------
    task automatic mode_predict(input t_cmd_item it);
        int                 first;
        int                 last;
        int                 best_cnt;
        int                 tally [ID_COUNT];
        logic [IDENT_W-1:0] best_id;
        logic [IDENT_W-1:0] id;
        t_mode_result       res;
        if (it.cmd == CMD_LOAD) begin
            if (seq_len < MAX_LEN) begin
                seq_mem[seq_len] = it.ident;
                seq_len++;
                if (it.ident > peak_ident)
                    peak_ident = it.ident;
            end
        end else begin
            first    = (it.range_first == 0) ? 1 : int'(it.range_first);
            last     = (int'(it.range_last) > seq_len) ? seq_len : int'(it.range_last);
            best_id  = peak_ident;
            best_cnt = 0;
            tally    = '{default: 0};
            for (int p = first - 1; p < last; p++) begin
                id = seq_mem[p];
                tally[id]++;
                if (tally[id] > best_cnt || (tally[id] == best_cnt && id > best_id)) begin
                    best_cnt = tally[id];
                    best_id  = id;
                end
            end
            res.ident = best_id;
            res.count = best_cnt[COUNT_W-1:0];
            mode_expect = {mode_expect, res};
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic push_load(input logic [IDENT_W-1:0] ident);
        t_cmd_item it;
        it.cmd         = CMD_LOAD;
        it.ident       = ident;
        it.range_first = RANGE_W'($urandom);  // don't-care on a load
        it.range_last  = RANGE_W'($urandom);
        it.pace        = gen_pace;
        cmd_queue = {cmd_queue, it};
        if (gen_len < MAX_LEN)
            gen_len++;
    endtask

    task automatic push_query(input int first, input int last);
        t_cmd_item it;
        it.cmd         = CMD_QUERY;
        it.ident       = IDENT_W'($urandom);  // don't-care on a query
        it.range_first = RANGE_W'(first);
        it.range_last  = RANGE_W'(last);
        it.pace        = gen_pace;
        cmd_queue = {cmd_queue, it};
    endtask

    // Loads mostly come from a small sliding pool so that ranges have real
    // repeats and ties; the rest are random identifiers or the two extremes.
    task automatic push_random_load();
        int r;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 15) == 0)
            pool_base = IDENT_W'($urandom);
        if (r < 60)
            push_load(pool_base + IDENT_W'($urandom_range(0, 3)));
        else if (r < 85)
            push_load(IDENT_W'($urandom));
        else
            push_load($urandom_range(0, 1) ? '1 : '0);
    endtask

    // Most queries are short windows so the run stays fast; some span the
    // whole store, some are inverted, some take raw 11-bit values.
    task automatic push_random_query();
        int r;
        int first;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            first = $urandom_range(0, gen_len + 1);
            push_query(first, first + $urandom_range(0, 20));
        end else if (r < 75) begin
            push_query($urandom_range(0, 2), $urandom_range(gen_len, 2047));
        end else if (r < 85) begin
            first = $urandom_range(1, 2047);
            push_query(first, $urandom_range(0, first - 1));
        end else begin
            push_query($urandom_range(0, 2047), $urandom_range(0, 2047));
        end
    endtask

    // ------------------------------------------------------------------
    // Idle decisions per pace
    // ------------------------------------------------------------------
    function automatic bit source_idles(input t_pace pace);
        case (pace)
            PACE_SLOW_SINK:   return $urandom_range(0, 99) < 9;
            PACE_SLOW_SOURCE: return $urandom_range(0, 99) < 67;
            default:          return 1'b0;
        endcase
    endfunction

    function automatic bit sink_idles(input t_pace pace);
        case (pace)
            PACE_SLOW_SINK:   return $urandom_range(0, 99) < 67;
            PACE_SLOW_SOURCE: return $urandom_range(0, 99) < 9;
            default:          return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: holds a transaction until accepted, then feeds the predictor.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready)
                mode_predict(cmd_on_bus);
            if (!cmd_if.valid || cmd_if.ready) begin
                if (cmd_queue.size() > 0 && !source_idles(cmd_queue[0].pace)) begin
                    cmd_on_bus = cmd_queue.pop_front();
                    cmd_if.valid       <= 1'b1;
                    cmd_if.cmd         <= cmd_on_bus.cmd;
                    cmd_if.ident       <= cmd_on_bus.ident;
                    cmd_if.range_first <= cmd_on_bus.range_first;
                    cmd_if.range_last  <= cmd_on_bus.range_last;
                    bus_pace           <= cmd_on_bus.pace;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compares each result transaction with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_mode_result exp_res;
        if (!i_rst_n) begin
            mode_if.ready <= 1'b0;
        end else begin
            if (mode_if.valid && mode_if.ready) begin
                if (mode_expect.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got ident %0d count %0d",
                             $time, mode_if.mode_ident, mode_if.mode_count);
                    err_cnt++;
                end else begin
                    exp_res = mode_expect.pop_front();
                    if (mode_if.mode_ident !== exp_res.ident) begin
                        $display("%0t: mode_ident mismatch, expected %0d, got %0d",
                                 $time, exp_res.ident, mode_if.mode_ident);
                        err_cnt++;
                    end
                    if (mode_if.mode_count !== exp_res.count) begin
                        $display("%0t: mode_count mismatch, expected %0d, got %0d",
                                 $time, exp_res.count, mode_if.mode_count);
                        err_cnt++;
                    end
                end
            end
            mode_if.ready <= !sink_idles(bus_pace);
        end
    end

    // Watchdog: too long without any transaction on either side.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((cmd_if.valid && cmd_if.ready) || (mode_if.valid && mode_if.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
                $display("tb_range_mode_query NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build all stimulus, release reset, drain, report.
    // ------------------------------------------------------------------
    initial begin
        i_rst_n            = 1'b0;
        cmd_if.valid       = 1'b0;
        cmd_if.cmd         = CMD_LOAD;
        cmd_if.ident       = '0;
        cmd_if.range_first = '0;
        cmd_if.range_last  = '0;
        mode_if.ready      = 1'b0;
        bus_pace           = PACE_SLOW_SINK;
        seq_len            = 0;
        peak_ident         = '0;
        gen_len            = 0;
        pool_base          = '0;
        err_cnt            = 0;
        stall_cycles       = 0;

        // Directed: empty store, ties, clamping, position zero, empty ranges.
        gen_pace = PACE_SLOW_SINK;
        push_query(1, 1);            // nothing loaded
        push_query(0, 2047);         // nothing loaded, clamps to empty
        push_load(5);
        push_load(1023);
        push_load(5);
        push_load(1023);             // 5 and 1023 tie at two each
        push_load(0);
        push_query(0, 4);            // first position zero, tie to larger
        push_query(1, 2047);         // last clamped to loaded length
        push_query(3, 3);
        push_query(5, 5);            // identifier zero beats the largest on count
        push_query(4, 2);            // inverted range
        push_query(2047, 2047);      // beyond loaded length
        push_query(1024, 1024);
        push_load(10'h2AA);
        push_load(10'h155);
        push_query(1, 1024);
        push_query(6, 7);            // single-count tie between two fresh entries

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 3)
                gen_pace = PACE_SLOW_SOURCE;
            if (n == 2 * RAND_ITEMS / 3) begin
                // Queries across everything loaded so far, clamped and empty.
                push_query(1, 1024);
                push_query(0, 2047);
                push_query(1024, 1024);
                push_query(1024, 2047);
                push_query(1000, 1030);
                gen_pace = PACE_FREE;
            end
            if ($urandom_range(0, 99) < ((gen_len < MAX_LEN) ? 55 : 10))
                push_random_load();
            else
                push_random_query();
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || cmd_if.valid)
            @(posedge i_clk);
        while (mode_expect.size() != 0)
            @(posedge i_clk);
        // Run on for TAIL_CYCLES to catch any stray result.
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_cnt == 0 && mode_expect.size() == 0)
            $display("tb_range_mode_query OK");
        else
            $display("tb_range_mode_query NOT OK");
        $finish;
    end

endmodule
